// File: hw/rtl/lsep_pkg.sv
// Shared types and constants for the LSB payload extractor.
`default_nettype none
package lsep_pkg;

    localparam int LSEP_HEADER_BITS = 24;
    localparam int LSEP_LEN_W       = 24;
    localparam int LSEP_BYTE_W      = 8;

    typedef struct packed {
        logic [LSEP_LEN_W-1:0]  message_length;
        logic                   last;
        logic                   byte_valid;
        logic [LSEP_BYTE_W-1:0] data_byte;
    } t_result;

endpackage
`default_nettype wire

// File: hw/rtl/lsb_stego_payload_extractor.sv
// Top level of the LSB payload extractor.
//  channel   dir  tdata                                   tuser           tlast
//  s_axis    in   red[7:0] green[15:8] blue[23:16]        start_of_image  -
//  m_axis    out  data_byte[7:0] message_length[31:8]     byte_valid      last
// One pixel per cycle while the queue has room; a result passes the front register,
// the queue and the output register in that order. Pixels are taken whenever the queue
// has room; a stalled output only blocks input once the queue fills.
// Synchronous active-low reset puts the extractor in the header phase.
`default_nettype none
module lsb_stego_payload_extractor
    import lsep_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // red, green, blue
    input  wire logic        s_axis_tuser,  // start_of_image
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // data_byte, message_length
    output logic             m_axis_tuser,  // byte_valid
    output logic             m_axis_tlast   // last
);

    logic    accept;
    logic    push;
    logic    pop;
    logic    q_valid;
    t_result front_res;
    t_result q_data;
    t_result out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    lsep_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pixel  (s_axis_tdata),
        .i_sof    (s_axis_tuser),
        .o_push   (push),
        .o_result (front_res)
    );

    lsep_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_res),
        .o_space (s_axis_tready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    lsep_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (q_data),
        .o_pop   (pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_res)
    );

    assign m_axis_tdata = {out_res.message_length, out_res.data_byte};
    assign m_axis_tuser = out_res.byte_valid;
    assign m_axis_tlast = out_res.last;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |-> $past(s_axis_tready) || !$past(accept))
        else $error("queue push without room");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[31:8] == 24'd0)
        else $error("byteless result not a zero-length end");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> m_axis_tvalid)
        else $error("output stage lost a popped result");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/lsep_front.sv
// Front end: gathers pixel LSBs, decodes the header and assembles message bytes.
`default_nettype none
module lsep_front
    import lsep_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [23:0]     i_pixel,
    input  wire logic            i_sof,
    output logic                 o_push,
    output t_result              o_result
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    logic [1:0]            r_phase, n_phase;
    logic [23:0]           r_hdr, n_hdr;
    logic [4:0]            r_hcnt, n_hcnt;
    logic [LSEP_LEN_W-1:0] r_len, n_len;
    logic [7:0]            r_acc, n_acc;
    logic [2:0]            r_acnt, n_acnt;
    logic [LSEP_LEN_W-1:0] r_rem, n_rem;
    logic                  n_push;
    t_result               n_res;

    always_comb begin
        logic [2:0] bits;
        logic       last_b;
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_hcnt  = r_hcnt;
        n_len   = r_len;
        n_acc   = r_acc;
        n_acnt  = r_acnt;
        n_rem   = r_rem;
        n_push  = 1'b0;
        n_res   = '0;
        last_b  = 1'b0;
        if (i_sof) begin
            n_phase = PH_HEADER;
            n_hdr   = '0;
            n_hcnt  = '0;
            n_len   = '0;
            n_acc   = '0;
            n_acnt  = '0;
            n_rem   = '0;
        end
        // red first, then green, then blue
        bits = {i_pixel[16], i_pixel[8], i_pixel[0]};
        for (int k = 0; k < 3; k++) begin
            if (n_phase == PH_HEADER) begin
                n_hdr  = {n_hdr[22:0], bits[k]};
                n_hcnt = n_hcnt + 5'd1;
                if (n_hcnt >= 5'(LSEP_HEADER_BITS)) begin
                    n_len  = {n_hdr[7:0], n_hdr[15:8], n_hdr[23:16]};
                    n_rem  = n_len;
                    n_acc  = '0;
                    n_acnt = '0;
                    if (n_len == '0) begin
                        if (!n_push) begin
                            n_push = 1'b1;
                            n_res  = '{message_length: n_len, last: 1'b1,
                                       byte_valid: 1'b0, data_byte: 8'd0};
                        end
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end else if (n_phase == PH_DATA) begin
                n_acc = {n_acc[6:0], bits[k]};
                if (n_acnt == 3'd7) begin
                    n_acnt = '0;
                    n_rem  = n_rem - 24'd1;
                    last_b = (n_rem == '0);
                    if (!n_push) begin
                        n_push = 1'b1;
                        n_res  = '{message_length: n_len, last: last_b,
                                   byte_valid: 1'b1, data_byte: n_acc};
                    end
                    n_acc = '0;
                    if (last_b) begin
                        n_phase = PH_DONE;
                    end
                end else begin
                    n_acnt = n_acnt + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hdr   <= '0;
            r_hcnt  <= '0;
            r_len   <= '0;
            r_acc   <= '0;
            r_acnt  <= '0;
            r_rem   <= '0;
            o_push  <= 1'b0;
        end else begin
            o_push <= i_accept & n_push;
            if (i_accept) begin
                r_phase <= n_phase;
                r_hdr   <= n_hdr;
                r_hcnt  <= n_hcnt;
                r_len   <= n_len;
                r_acc   <= n_acc;
                r_acnt  <= n_acnt;
                r_rem   <= n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            o_result <= n_res;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/lsep_fifo.sv
// Small register queue between front end and output stage.
`default_nettype none
module lsep_fifo
    import lsep_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_space,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_result      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    // With a push in flight, two free slots are required to cover the front end's registered push.
    assign o_space = i_push ? (r_count < CW'(DEPTH - 1)) : (r_count < CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/lsep_out.sv
// Output stage: registered result toward the downstream stream.
`default_nettype none
module lsep_out
    import lsep_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_data,
    output logic         o_pop,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_data
);

    assign o_pop = i_valid && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (o_pop) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_data <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: test/tb_lsb_stego_payload_extractor.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LSB payload extractor: directed rows, then random images.
module tb_lsb_stego_payload_extractor;
    import lsep_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LIVE_ITEMS  = 1450;
    localparam int RX_HOLD     = 80;

    typedef enum logic [1:0] {PH_HDR, PH_DATA, PH_DONE} t_phase;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       sof;
        bit         typed;
        t_result    want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // red[7:0], green[15:8], blue[23:16]
    logic        s_axis_tuser;   // start_of_image
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // data_byte[7:0], message_length[31:8]
    logic        m_axis_tuser;   // byte_valid
    logic        m_axis_tlast;   // last

    // extractor state mirror
    t_phase      ex_phase;
    logic [23:0] hdr_shift;
    int          hdr_cnt;
    logic [23:0] msg_len;
    logic [7:0]  byte_acc;
    int          acc_cnt;
    logic [23:0] bytes_left;

    t_result     byte_q[$];
    t_row        dir_rows[$];
    int          n_err;
    int          n_live;
    int          cyc;
    bit          calm;
    bit          hold_pending;

    lsb_stego_payload_extractor uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_result mk_res(logic [7:0] data, logic valid, logic fin,
                                       logic [23:0] len);
        t_result res;
        res.data_byte      = data;
        res.byte_valid     = valid;
        res.last           = fin;
        res.message_length = len;
        return res;
    endfunction

    function automatic logic [7:0] lsb_with_noise(logic lsb);
        logic [7:0] v;
        v = 8'($urandom);
        return {v[7:1], lsb};
    endfunction

    task automatic clear_extract();
        ex_phase   = PH_HDR;
        hdr_shift  = '0;
        hdr_cnt    = 0;
        msg_len    = '0;
        byte_acc   = '0;
        acc_cnt    = 0;
        bytes_left = '0;
    endtask

    task automatic extract_pixel(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, input logic sof,
                                 output bit got, output t_result res);
        logic [2:0] lsbs;
        logic       fin;
        got = 0;
        res = '0;
        if (sof)
            clear_extract();
        lsbs = {b[0], g[0], r[0]};
        for (int k = 0; k < 3; k++) begin
            case (ex_phase)
                PH_HDR: begin
                    hdr_shift = {hdr_shift[22:0], lsbs[k]};
                    hdr_cnt++;
                    if (hdr_cnt >= LSEP_HEADER_BITS) begin
                        // length bytes arrive lowest first
                        msg_len    = {hdr_shift[7:0], hdr_shift[15:8], hdr_shift[23:16]};
                        bytes_left = msg_len;
                        byte_acc   = '0;
                        acc_cnt    = 0;
                        if (msg_len == 0) begin
                            if (!got) begin
                                res = mk_res(8'h00, 1'b0, 1'b1, msg_len);
                                got = 1;
                            end
                            ex_phase = PH_DONE;
                        end else begin
                            ex_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    byte_acc = {byte_acc[6:0], lsbs[k]};
                    acc_cnt++;
                    if (acc_cnt >= 8) begin
                        acc_cnt    = 0;
                        bytes_left = bytes_left - 24'd1;
                        fin        = (bytes_left == 0);
                        if (!got) begin
                            res = mk_res(byte_acc, 1'b1, fin, msg_len);
                            got = 1;
                        end
                        byte_acc = '0;
                        if (fin)
                            ex_phase = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic add_row(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic sof,
                           bit typed, t_result want);
        t_row row;
        row.r     = r;
        row.g     = g;
        row.b     = b;
        row.sof   = sof;
        row.typed = typed;
        row.want  = want;
        dir_rows  = {dir_rows, row};
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic sof,
                              bit typed, t_result want);
        bit      got;
        t_result res;
        while (!calm && $urandom_range(99) < 19) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        s_axis_tuser  <= sof;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (!(ex_phase == PH_DONE && !sof))
            n_live++;
        extract_pixel(r, g, b, sof, got, res);
        if (typed)
            byte_q = {byte_q, want};
        else if (got)
            byte_q = {byte_q, res};
        @(negedge i_clk);
    endtask

    task automatic send_image();
        int          pick;
        int          n_data;
        bit          trunc;
        logic [23:0] len;
        logic [23:0] hdr;
        pick  = $urandom_range(99);
        trunc = 0;
        if (pick < 8) begin
            len = '0;
        end else if (pick == 8) begin
            len   = '1;
            trunc = 1;
        end else if (pick < 14) begin
            len   = 24'($urandom);
            trunc = 1;
        end else if (pick >= 90 && pick < 95) begin
            // loose pixels, occasional restarts
            repeat ($urandom_range(1, 5))
                push_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                           $urandom_range(3) == 0, 0, '0);
            return;
        end else begin
            len = 24'($urandom_range(1, 24));
        end
        hdr = {len[7:0], len[15:8], len[23:16]};
        // broken header: restart before it completes
        if (pick >= 95) begin
            n_data = $urandom_range(1, 7);
        end else begin
            n_data = 8;
        end
        for (int p = 0; p < n_data; p++)
            push_pixel(lsb_with_noise(hdr[23 - 3 * p]), lsb_with_noise(hdr[22 - 3 * p]),
                       lsb_with_noise(hdr[21 - 3 * p]), p == 0, 0, '0);
        if (pick >= 95)
            return;
        n_data = (int'(len) * 8 + 2) / 3;
        if (trunc && n_data > 30)
            n_data = $urandom_range(1, 30);
        repeat (n_data)
            push_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 0, '0);
        repeat ($urandom_range(0, 2))
            push_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 0, '0);
    endtask

    // receiver side
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD) @(negedge i_clk);
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 19);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (byte_q.size() == 0) begin
                $error("unexpected item: data_byte %h message_length %h",
                       m_axis_tdata[7:0], m_axis_tdata[31:8]);
                n_err++;
            end else begin
                want = byte_q.pop_front();
                if (m_axis_tdata[7:0] !== want.data_byte) begin
                    $error("data_byte: expected %h, got %h", want.data_byte,
                           m_axis_tdata[7:0]);
                    n_err++;
                end
                if (m_axis_tuser !== want.byte_valid) begin
                    $error("byte_valid: expected %b, got %b", want.byte_valid, m_axis_tuser);
                    n_err++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_axis_tlast);
                    n_err++;
                end
                if (m_axis_tdata[31:8] !== want.message_length) begin
                    $error("message_length: expected %h, got %h", want.message_length,
                           m_axis_tdata[31:8]);
                    n_err++;
                end
            end
        end
    end

    initial begin
        bit hold_done;
        bit drain_done;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        n_err         = 0;
        n_live        = 0;
        cyc           = 0;
        calm          = 0;
        hold_pending  = 0;
        hold_done     = 0;
        drain_done    = 0;
        clear_extract();

        // zero-length header right after reset, no start flag, upper bits set
        repeat (7) add_row(8'hFE, 8'hFE, 8'hFE, 1'b0, 0, '0);
        add_row(8'hFE, 8'hFE, 8'hFE, 1'b0, 1, mk_res(8'h00, 1'b0, 1'b1, 24'd0));
        // done: ignored
        add_row(8'hFF, 8'hFF, 8'hFF, 1'b0, 0, '0);
        // restart, length 1, trailing blue bit dropped
        add_row(8'h00, 8'h00, 8'h00, 1'b1, 0, '0);
        add_row(8'h00, 8'h00, 8'h00, 1'b0, 0, '0);
        add_row(8'h00, 8'h01, 8'h00, 1'b0, 0, '0);
        repeat (5) add_row(8'h00, 8'h00, 8'h00, 1'b0, 0, '0);
        add_row(8'hFF, 8'hFF, 8'hFF, 1'b0, 0, '0);
        add_row(8'hFF, 8'hFF, 8'hFF, 1'b0, 0, '0);
        add_row(8'hFF, 8'hFF, 8'hFE, 1'b0, 1, mk_res(8'hFF, 1'b1, 1'b1, 24'd1));
        add_row(8'h01, 8'h01, 8'h01, 1'b0, 0, '0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i])
            push_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].sof,
                       dir_rows[i].typed, dir_rows[i].want);

        while (n_live < LIVE_ITEMS) begin
            calm = (n_live >= 300 && n_live < 500);
            if (!hold_done && n_live >= 700) begin
                hold_done    = 1;
                hold_pending = 1;
            end
            if (!drain_done && n_live >= 1000) begin
                drain_done = 1;
                s_axis_tvalid <= 1'b0;
                wait (byte_q.size() == 0);
                @(negedge i_clk);
            end
            send_image();
        end
        s_axis_tvalid <= 1'b0;

        wait (byte_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (n_err == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
